FILE: rtl/frh_pkg.sv
package frh_pkg;

    localparam int MAX_BUCKETS_DEF = 256;
    localparam int COUNT_BITS_DEF  = 32;
    localparam int MULT_W_DEF      = $clog2(MAX_BUCKETS_DEF + 1);

    localparam int DATA_W    = 32;
    localparam int BCOUNT_W  = 9;
    localparam int INDEX_W   = 8;
    localparam int MODE_W    = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [MODE_W-1:0] MODE_SAMPLE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_NODATA = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MIN    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MAX    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BUCKET_COUNT = 2'd2;

    localparam logic signed [DATA_W-1:0] RANGE_MIN_RST    = 32'sd0;
    localparam logic signed [DATA_W-1:0] RANGE_MAX_RST    = 32'sd16777216;
    localparam logic [BCOUNT_W-1:0]      BUCKET_COUNT_RST = 9'd256;

    // request to the shared multiply-then-divide unit
    typedef struct packed {
        logic start;
        logic wide_q;
    } t_arith_req;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] quot;
    } t_arith_rsp;

endpackage

FILE: rtl/frh_muldiv.sv
module frh_muldiv #(
    parameter int MW = frh_pkg::MULT_W_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  frh_pkg::t_arith_req       i_req,
    input  logic [frh_pkg::DATA_W-1:0] i_a,
    input  logic [MW-1:0]             i_m,
    input  logic [frh_pkg::DATA_W-1:0] i_dv,
    output frh_pkg::t_arith_rsp       o_rsp
);

    localparam int DW = frh_pkg::DATA_W;
    localparam int PW = DW + MW;

    localparam logic [1:0] U_IDLE = 2'd0;
    localparam logic [1:0] U_MUL  = 2'd1;
    localparam logic [1:0] U_LOAD = 2'd2;
    localparam logic [1:0] U_DIV  = 2'd3;

    logic [1:0]    r_phase;
    logic [5:0]    r_cnt;
    logic          r_done;
    logic          r_wide;
    logic [DW-1:0] r_a;
    logic [MW-1:0] r_m;
    logic [DW-1:0] r_dv;
    logic [PW-1:0] r_acc;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_dsh;
    logic [DW-1:0] r_q;

    logic [DW:0] trial;
    logic [DW:0] diff;
    logic        fits;

    // one quotient bit per cycle, restoring
    assign trial = {r_rem, r_dsh[DW-1]};
    assign diff  = trial - {1'b0, r_dv};
    assign fits  = trial >= {1'b0, r_dv};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= U_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_phase)
                U_IDLE: begin
                    if (i_req.start) begin
                        r_phase <= U_MUL;
                        r_cnt   <= 6'(MW - 1);
                    end
                end
                U_MUL: begin
                    if (r_cnt == '0) begin
                        r_phase <= U_LOAD;
                    end else begin
                        r_cnt <= r_cnt - 6'd1;
                    end
                end
                U_LOAD: begin
                    r_phase <= U_DIV;
                    r_cnt   <= r_wide ? 6'(DW - 1) : 6'(MW - 1);
                end
                U_DIV: begin
                    if (r_cnt == '0) begin
                        r_phase <= U_IDLE;
                        r_done  <= 1'b1;
                    end else begin
                        r_cnt <= r_cnt - 6'd1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_phase)
            U_IDLE: begin
                if (i_req.start) begin
                    r_a    <= i_a;
                    r_m    <= i_m;
                    r_dv   <= i_dv;
                    r_acc  <= '0;
                    r_wide <= i_req.wide_q;
                    r_q    <= '0;
                end
            end
            U_MUL: begin
                // multiplier bits taken msb first
                r_acc <= (r_acc << 1) + (r_m[MW-1] ? PW'(r_a) : PW'(0));
                r_m   <= r_m << 1;
            end
            U_LOAD: begin
                // upper part is already below the divisor, so only the low bits iterate
                if (r_wide) begin
                    r_rem <= DW'(r_acc[PW-1:DW]);
                    r_dsh <= r_acc[DW-1:0];
                end else begin
                    r_rem <= r_acc[PW-1:MW];
                    r_dsh <= DW'(r_acc[MW-1:0]) << (DW - MW);
                end
            end
            U_DIV: begin
                r_rem <= fits ? diff[DW-1:0] : trial[DW-1:0];
                r_dsh <= r_dsh << 1;
                r_q   <= {r_q[DW-2:0], fits};
            end
        endcase
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;

endmodule

FILE: rtl/fixed_range_histogram_core.sv
// flow: a nodata event, an out-of-range sample or index, or the unused mode goes straight to the result;
// a bucket read makes one pass of the bit-serial mul/div unit for its lower border, an in-range sample
// two (bucket, then border); no border pass is made while the range is in error
// throughput: one item at a time, the next beat is taken once the result is registered
// reset: synchronous active low; a clearing pass over all MAX_BUCKETS entries follows reset,
// during which no input beat is taken (configuration writes are still taken)
module fixed_range_histogram_core #(
    parameter int MAX_BUCKETS = frh_pkg::MAX_BUCKETS_DEF,
    parameter int COUNT_BITS  = frh_pkg::COUNT_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [frh_pkg::MODE_W-1:0]          i_mode,
    input  logic signed [frh_pkg::DATA_W-1:0]   i_sample,
    input  logic [frh_pkg::INDEX_W-1:0]         i_bucket_index,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic                                o_in_range,
    output logic [frh_pkg::INDEX_W-1:0]         o_bucket_hit,
    output logic [frh_pkg::DATA_W-1:0]          o_bucket_total,
    output logic signed [frh_pkg::DATA_W-1:0]   o_lower_border,
    output logic [frh_pkg::DATA_W-1:0]          o_nodata_total,
    output logic [frh_pkg::DATA_W-1:0]          o_valid_total,
    output logic                                o_config_error,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [frh_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [frh_pkg::DATA_W-1:0]          i_cfg_data
);

    localparam int DW = frh_pkg::DATA_W;
    localparam int NW = $clog2(MAX_BUCKETS + 1);
    localparam int AW = $clog2(MAX_BUCKETS);
    localparam int CW = (NW > frh_pkg::BCOUNT_W) ? NW : frh_pkg::BCOUNT_W;
    localparam int IW = (NW > frh_pkg::INDEX_W) ? NW : frh_pkg::INDEX_W;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_BUCKET = 3'd3;
    localparam logic [2:0] S_RD     = 3'd4;
    localparam logic [2:0] S_UPD    = 3'd5;
    localparam logic [2:0] S_BORDER = 3'd6;
    localparam logic [2:0] S_DONE   = 3'd7;

    logic [2:0]                    r_state;
    logic [2:0]                    n_state;
    logic [AW-1:0]                 r_clr_addr;
    logic [COUNT_BITS-1:0]         r_nodata;
    logic [COUNT_BITS-1:0]         r_valid_cnt;
    logic                          r_out_valid;

    logic signed [DW-1:0]          r_range_min;
    logic signed [DW-1:0]          r_range_max;
    logic [frh_pkg::BCOUNT_W-1:0]  r_bucket_count;

    logic [frh_pkg::MODE_W-1:0]    r_mode;
    logic signed [DW-1:0]          r_sample;
    logic [frh_pkg::INDEX_W-1:0]   r_idx;
    logic                          r_inr;
    logic [frh_pkg::INDEX_W-1:0]   r_hit;
    logic [AW-1:0]                 r_b;
    logic [DW-1:0]                 r_tot;
    logic signed [DW-1:0]          r_border;
    logic [COUNT_BITS-1:0]         r_rdata;
    logic [COUNT_BITS-1:0]         r_counts [MAX_BUCKETS];

    logic                          r_out_inr;
    logic [frh_pkg::INDEX_W-1:0]   r_out_hit;
    logic [DW-1:0]                 r_out_tot;
    logic signed [DW-1:0]          r_out_border;
    logic [DW-1:0]                 r_out_nodata;
    logic [DW-1:0]                 r_out_valid_tot;
    logic                          r_out_err;

    logic                          cfg_err;
    logic [DW-1:0]                 span;
    logic [NW-1:0]                 buckets_used;
    logic [NW-1:0]                 bucket_lim;
    logic                          out_of_range;
    logic                          idx_ok;
    logic [NW-1:0]                 q_bucket;
    logic [AW-1:0]                 clamp_b;
    logic                          nodata_inc;
    logic                          bucket_inc;
    logic                          load_out;
    logic [COUNT_BITS-1:0]         upd_val;
    logic                          mem_we;
    logic [AW-1:0]                 mem_addr;
    logic [COUNT_BITS-1:0]         mem_wdata;

    frh_pkg::t_arith_req           arith_req;
    frh_pkg::t_arith_rsp           arith_rsp;
    logic [DW-1:0]                 arith_a;
    logic [NW-1:0]                 arith_m;
    logic [DW-1:0]                 arith_dv;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_min    <= frh_pkg::RANGE_MIN_RST;
            r_range_max    <= frh_pkg::RANGE_MAX_RST;
            r_bucket_count <= frh_pkg::BUCKET_COUNT_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                frh_pkg::CFG_RANGE_MIN:    r_range_min    <= i_cfg_data;
                frh_pkg::CFG_RANGE_MAX:    r_range_max    <= i_cfg_data;
                frh_pkg::CFG_BUCKET_COUNT: r_bucket_count <= i_cfg_data[frh_pkg::BCOUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign cfg_err      = r_range_min >= r_range_max;
    assign span         = DW'(r_range_max - r_range_min);
    assign out_of_range = (r_sample < r_range_min) || (r_sample > r_range_max);

    always_comb begin
        if (r_bucket_count == '0) begin
            buckets_used = NW'(1);
        end else if (CW'(r_bucket_count) > CW'(MAX_BUCKETS)) begin
            buckets_used = NW'(MAX_BUCKETS);
        end else begin
            buckets_used = NW'(r_bucket_count);
        end
    end

    assign bucket_lim = buckets_used - NW'(1);
    assign idx_ok     = IW'(r_idx) < IW'(buckets_used);
    assign q_bucket   = arith_rsp.quot[NW-1:0];
    // sample equal to the upper limit lands in the top bucket
    assign clamp_b    = (q_bucket > bucket_lim) ? AW'(bucket_lim) : AW'(q_bucket);

    // for a sample the first pass finds the bucket, the second its lower border; a read makes only the border pass
    always_comb begin
        arith_req.start  = 1'b0;
        arith_req.wide_q = 1'b0;
        arith_a          = DW'(r_sample - r_range_min);
        arith_m          = buckets_used;
        arith_dv         = span;
        if (r_state == S_DECIDE) begin
            arith_req.start = (r_mode == frh_pkg::MODE_SAMPLE) && !cfg_err && !out_of_range;
        end else begin
            arith_req.start  = (r_state == S_UPD) && !cfg_err;
            arith_req.wide_q = 1'b1;
            arith_a          = span;
            arith_m          = NW'(r_b);
            arith_dv         = DW'(buckets_used);
        end
    end

    frh_muldiv #(
        .MW (NW)
    ) u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (arith_req),
        .i_a     (arith_a),
        .i_m     (arith_m),
        .i_dv    (arith_dv),
        .o_rsp   (arith_rsp)
    );

    assign nodata_inc = (r_state == S_DECIDE) &&
                        ((r_mode == frh_pkg::MODE_NODATA) ||
                         ((r_mode == frh_pkg::MODE_SAMPLE) && (cfg_err || out_of_range)));
    assign bucket_inc = (r_state == S_UPD) && (r_mode == frh_pkg::MODE_SAMPLE) &&
                        (r_rdata != CNT_MAX);
    assign upd_val    = bucket_inc ? r_rdata + COUNT_BITS'(1) : r_rdata;
    assign load_out   = (r_state == S_DONE) && (!r_out_valid || i_ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == AW'(MAX_BUCKETS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                unique case (r_mode)
                    frh_pkg::MODE_SAMPLE: n_state = arith_req.start ? S_BUCKET : S_DONE;
                    frh_pkg::MODE_NODATA: n_state = S_DONE;
                    frh_pkg::MODE_READ:   n_state = idx_ok ? S_RD : S_DONE;
                    frh_pkg::MODE_UNUSED: n_state = S_DONE;
                endcase
            end
            S_BUCKET: begin
                if (arith_rsp.done) begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                n_state = S_UPD;
            end
            S_UPD: begin
                n_state = cfg_err ? S_DONE : S_BORDER;
            end
            S_BORDER: begin
                if (arith_rsp.done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_nodata    <= '0;
            r_valid_cnt <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (nodata_inc && (r_nodata != CNT_MAX)) begin
                r_nodata <= r_nodata + COUNT_BITS'(1);
            end
            // bucket not saturated, so the total cannot lag behind it
            if (bucket_inc && (r_valid_cnt != CNT_MAX)) begin
                r_valid_cnt <= r_valid_cnt + COUNT_BITS'(1);
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && i_valid) begin
            r_mode   <= i_mode;
            r_sample <= i_sample;
            r_idx    <= i_bucket_index;
            r_inr    <= 1'b0;
            r_hit    <= '0;
            r_tot    <= '0;
            r_border <= '0;
        end
        if (r_state == S_DECIDE) begin
            if (arith_req.start) begin
                r_inr <= 1'b1;
            end
            if (r_mode == frh_pkg::MODE_READ) begin
                r_hit <= r_idx;
                r_b   <= AW'(r_idx);
            end
        end
        if ((r_state == S_BUCKET) && arith_rsp.done) begin
            r_b   <= clamp_b;
            r_hit <= frh_pkg::INDEX_W'(clamp_b);
        end
        if (r_state == S_UPD) begin
            r_tot <= DW'(upd_val);
        end
        if ((r_state == S_BORDER) && arith_rsp.done) begin
            r_border <= r_range_min + signed'(arith_rsp.quot);
        end
        if (load_out) begin
            r_out_inr       <= r_inr;
            r_out_hit       <= r_hit;
            r_out_tot       <= r_tot;
            r_out_border    <= r_border;
            r_out_nodata    <= DW'(r_nodata);
            r_out_valid_tot <= DW'(r_valid_cnt);
            r_out_err       <= cfg_err;
        end
    end

    // bucket store: clearing sweep after reset, then read-modify-write
    assign mem_we    = (r_state == S_CLEAR) || bucket_inc;
    assign mem_addr  = (r_state == S_CLEAR) ? r_clr_addr : r_b;
    assign mem_wdata = (r_state == S_CLEAR) ? '0 : upd_val;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_counts[mem_addr] <= mem_wdata;
        end
        if (r_state == S_RD) begin
            r_rdata <= r_counts[r_b];
        end
    end

    assign o_ready        = (r_state == S_IDLE);
    assign o_cfg_ready    = 1'b1;
    assign o_valid        = r_out_valid;
    assign o_in_range     = r_out_inr;
    assign o_bucket_hit   = r_out_hit;
    assign o_bucket_total = r_out_tot;
    assign o_lower_border = r_out_border;
    assign o_nodata_total = r_out_nodata;
    assign o_valid_total  = r_out_valid_tot;
    assign o_config_error = r_out_err;

endmodule

FILE: rtl/frh_checker.sv
module frh_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_valid,
    input logic                               o_ready,
    input logic                               o_valid,
    input logic                               i_ready,
    input logic                               o_in_range,
    input logic [frh_pkg::DATA_W-1:0]         o_bucket_total,
    input logic                               o_config_error
);

    // a stalled result stays on offer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result dropped while stalled");

    // clearing pass follows reset, so no beat is taken straight after it
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_ready)
        else $error("input taken during clearing pass");

    // one item at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("second beat taken while an item is in progress");

    // an in-range sample always leaves a non-empty bucket and a sound range
    a_hit_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_in_range |-> (o_bucket_total != '0) && !o_config_error)
        else $error("in-range result with empty bucket or range error");

endmodule

bind fixed_range_histogram_core frh_checker u_frh_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_ready        (o_ready),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_in_range     (o_in_range),
    .o_bucket_total (o_bucket_total),
    .o_config_error (o_config_error)
);

FILE: verif/frh_hist_checker.sv
`timescale 1ns / 1ps

module frh_hist_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              i_in_ready,
    input  logic [frh_pkg::MODE_W-1:0]        i_mode,
    input  logic signed [frh_pkg::DATA_W-1:0] i_sample,
    input  logic [frh_pkg::INDEX_W-1:0]       i_bucket_index,
    input  logic                              i_out_valid,
    input  logic                              i_out_ready,
    input  logic                              i_in_range,
    input  logic [frh_pkg::INDEX_W-1:0]       i_bucket_hit,
    input  logic [frh_pkg::DATA_W-1:0]        i_bucket_total,
    input  logic signed [frh_pkg::DATA_W-1:0] i_lower_border,
    input  logic [frh_pkg::DATA_W-1:0]        i_nodata_total,
    input  logic [frh_pkg::DATA_W-1:0]        i_valid_total,
    input  logic                              i_config_error,
    input  logic                              i_cfg_valid,
    input  logic                              i_cfg_ready,
    input  logic [frh_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [frh_pkg::DATA_W-1:0]        i_cfg_data,
    output int                                o_mismatches,
    output int                                o_pending
);
    import frh_pkg::*;

    localparam longint COUNT_SAT = (64'sd1 <<< COUNT_BITS_DEF) - 1;

    typedef struct packed {
        logic                      in_range;
        logic [INDEX_W-1:0]        bucket_hit;
        logic [DATA_W-1:0]         bucket_total;
        logic [DATA_W-1:0]         lower_border;
        logic [DATA_W-1:0]         nodata_total;
        logic [DATA_W-1:0]         valid_total;
        logic                      config_error;
    } hist_result_t;

    logic signed [DATA_W-1:0] range_lo;
    logic signed [DATA_W-1:0] range_hi;
    logic [BCOUNT_W-1:0]      bucket_cfg;
    longint                   bin_count [MAX_BUCKETS_DEF];
    longint                   nodata_cnt;
    longint                   valid_cnt;
    hist_result_t             hist_expected_q [$];
    int                       mismatch_cnt = 0;

    assign o_mismatches = mismatch_cnt;

    function automatic longint bump(longint c);
        return (c < COUNT_SAT) ? c + 1 : c;
    endfunction

    // bins the item into the histogram copy and builds the result it should give
    function automatic hist_result_t tally_item(logic [MODE_W-1:0] mode,
                                                logic signed [DATA_W-1:0] smp,
                                                logic [INDEX_W-1:0] idx);
        hist_result_t r;
        longint lo, hi, v, span, n, b;
        logic err;
        r = '0;
        lo = range_lo;
        hi = range_hi;
        v = smp;
        err = (lo >= hi);
        span = err ? 0 : hi - lo;
        n = bucket_cfg;
        if (n == 0)
            n = 1;
        if (n > MAX_BUCKETS_DEF)
            n = MAX_BUCKETS_DEF;
        case (mode)
            MODE_SAMPLE: begin
                if (err || v < lo || v > hi) begin
                    nodata_cnt = bump(nodata_cnt);
                end else begin
                    b = ((v - lo) * n) / span;
                    // top border belongs to the last bucket
                    if (b > n - 1)
                        b = n - 1;
                    if (bin_count[b] < COUNT_SAT) begin
                        bin_count[b] = bin_count[b] + 1;
                        valid_cnt = bump(valid_cnt);
                    end
                    r.in_range = 1'b1;
                    r.bucket_hit = b[INDEX_W-1:0];
                    r.bucket_total = bin_count[b][DATA_W-1:0];
                    r.lower_border = 64'(lo + (b * span) / n);
                end
            end
            MODE_NODATA: begin
                nodata_cnt = bump(nodata_cnt);
            end
            MODE_READ: begin
                r.bucket_hit = idx;
                if (idx < n) begin
                    r.bucket_total = bin_count[idx][DATA_W-1:0];
                    if (!err)
                        r.lower_border = 64'(lo + (idx * span) / n);
                end
            end
            default: ;
        endcase
        r.nodata_total = nodata_cnt[DATA_W-1:0];
        r.valid_total = valid_cnt[DATA_W-1:0];
        r.config_error = err;
        return r;
    endfunction

    task automatic compare_field(string fname, logic [DATA_W-1:0] want,
                                 logic [DATA_W-1:0] got);
        if (want !== got) begin
            mismatch_cnt++;
            $display("%0t: %s expected %h actual %h", $time, fname, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        hist_result_t want;
        if (!i_rst_n) begin
            range_lo = RANGE_MIN_RST;
            range_hi = RANGE_MAX_RST;
            bucket_cfg = BUCKET_COUNT_RST;
            foreach (bin_count[k])
                bin_count[k] = 0;
            nodata_cnt = 0;
            valid_cnt = 0;
            hist_expected_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (hist_expected_q.size() == 0) begin
                    mismatch_cnt++;
                    $display("%0t: result beat expected none actual bucket_hit %h total %h",
                             $time, i_bucket_hit, i_bucket_total);
                end else begin
                    want = hist_expected_q.pop_front();
                    compare_field("in_range", want.in_range, i_in_range);
                    compare_field("bucket_hit", want.bucket_hit, i_bucket_hit);
                    compare_field("bucket_total", want.bucket_total, i_bucket_total);
                    compare_field("lower_border", want.lower_border, i_lower_border);
                    compare_field("nodata_total", want.nodata_total, i_nodata_total);
                    compare_field("valid_total", want.valid_total, i_valid_total);
                    compare_field("config_error", want.config_error, i_config_error);
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_RANGE_MIN:    range_lo = i_cfg_data;
                    CFG_RANGE_MAX:    range_hi = i_cfg_data;
                    CFG_BUCKET_COUNT: bucket_cfg = i_cfg_data[BCOUNT_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                hist_expected_q.push_back(tally_item(i_mode, i_sample, i_bucket_index));
        end
        o_pending <= hist_expected_q.size();
    end

endmodule

FILE: verif/tb_fixed_range_histogram_core.sv
`timescale 1ns / 1ps

module tb_fixed_range_histogram_core;
    import frh_pkg::*;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_valid;
    logic                      o_ready;
    logic [MODE_W-1:0]         i_mode;
    logic signed [DATA_W-1:0]  i_sample;
    logic [INDEX_W-1:0]        i_bucket_index;
    logic                      o_valid;
    logic                      i_ready = 1'b0;
    logic                      o_in_range;
    logic [INDEX_W-1:0]        o_bucket_hit;
    logic [DATA_W-1:0]         o_bucket_total;
    logic signed [DATA_W-1:0]  o_lower_border;
    logic [DATA_W-1:0]         o_nodata_total;
    logic [DATA_W-1:0]         o_valid_total;
    logic                      o_config_error;
    logic                      i_cfg_valid;
    logic                      o_cfg_ready;
    logic [CFG_IDX_W-1:0]      i_cfg_index;
    logic [DATA_W-1:0]         i_cfg_data;

    int     hist_mismatches;
    int     results_owed;
    int     rx_wait;
    logic   no_idle;
    longint cur_lo;
    longint cur_hi;
    int     cur_n;

    fixed_range_histogram_core u_top (.*);

    frh_hist_checker u_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_valid),
        .i_in_ready     (o_ready),
        .i_mode         (i_mode),
        .i_sample       (i_sample),
        .i_bucket_index (i_bucket_index),
        .i_out_valid    (o_valid),
        .i_out_ready    (i_ready),
        .i_in_range     (o_in_range),
        .i_bucket_hit   (o_bucket_hit),
        .i_bucket_total (o_bucket_total),
        .i_lower_border (o_lower_border),
        .i_nodata_total (o_nodata_total),
        .i_valid_total  (o_valid_total),
        .i_config_error (o_config_error),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_mismatches   (hist_mismatches),
        .o_pending      (results_owed)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // result side: random stall after each beat, none while no_idle is set
    always @(posedge i_clk) begin
        int hold;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            rx_wait <= 0;
        end else if (i_ready && o_valid) begin
            hold = no_idle ? 0 : $urandom_range(0, 9);
            if (hold > 0)
                i_ready <= 1'b0;
            rx_wait <= hold;
        end else if (!i_ready) begin
            if (rx_wait <= 1)
                i_ready <= 1'b1;
            rx_wait <= (rx_wait > 0) ? rx_wait - 1 : 0;
        end
    end

    function automatic longint urand_u32();
        return longint'({32'd0, $urandom()});
    endfunction

    function automatic longint srand32();
        int s;
        s = $urandom();
        return s;
    endfunction

    // hold off the sample side until the histogram has answered everything
    task automatic settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (results_owed != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_range(longint lo, longint hi, int n);
        logic [DATA_W-1:0] upper;
        logic [BCOUNT_W-1:0] nb;
        settle();
        upper = $urandom();
        nb = n;
        write_reg(CFG_RANGE_MIN, lo[DATA_W-1:0]);
        write_reg(CFG_RANGE_MAX, hi[DATA_W-1:0]);
        // bits above the count field are junk and must be dropped
        write_reg(CFG_BUCKET_COUNT, {upper[DATA_W-1:BCOUNT_W], nb});
        cur_lo = lo;
        cur_hi = hi;
        cur_n = (nb == 0) ? 1 : (nb > MAX_BUCKETS_DEF) ? MAX_BUCKETS_DEF : nb;
    endtask

    task automatic send_item(logic [MODE_W-1:0] mode, logic [DATA_W-1:0] smp,
                             logic [INDEX_W-1:0] idx);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_mode <= mode;
        i_sample <= smp;
        i_bucket_index <= idx;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
    endtask

    task automatic random_range();
        longint lo, hi, span;
        int n, pick;
        case ($urandom_range(0, 5))
            0: begin
                lo = srand32();
                hi = srand32();
            end
            1, 2: begin
                span = $urandom_range(1, 32'h00FF_FFFF);
                lo = urand_u32() % ((64'sd1 <<< 32) - span) - (64'sd1 <<< 31);
                hi = lo + span;
            end
            3: begin
                // a span of at most 8 steps, often fewer than buckets, so borders can repeat and buckets stay empty
                span = $urandom_range(1, 8);
                lo = urand_u32() % ((64'sd1 <<< 32) - span) - (64'sd1 <<< 31);
                hi = lo + span;
            end
            4: begin
                lo = srand32();
                if (lo > 0)
                    lo = -lo;
                hi = srand32();
                if (hi < 0)
                    hi = -(hi + 1);
            end
            default: begin
                lo = srand32();
                hi = lo - $urandom_range(0, 1000);
                if (hi < -(64'sd1 <<< 31))
                    hi = lo;
            end
        endcase
        pick = $urandom_range(0, 9);
        if (pick < 6)
            n = $urandom_range(1, 16);
        else if (pick < 9)
            n = $urandom_range(17, 256);
        else
            n = $urandom_range(0, 511);
        set_range(lo, hi, n);
    endtask

    task automatic random_item();
        int pick;
        longint v;
        logic [INDEX_W-1:0] idx;
        logic [MODE_W-1:0] mode;
        pick = $urandom_range(0, 99);
        v = urand_u32();
        idx = $urandom_range(0, 255);
        mode = MODE_SAMPLE;
        if (pick >= 96) begin
            mode = MODE_UNUSED;
        end else if (pick >= 78) begin
            mode = MODE_READ;
            if ($urandom_range(0, 4) != 0)
                idx = $urandom_range(0, cur_n - 1);
        end else if (pick >= 65) begin
            mode = MODE_NODATA;
        end else if (pick < 50) begin
            if (cur_lo < cur_hi)
                v = cur_lo + urand_u32() % (cur_hi - cur_lo + 1);
        end else if (pick < 58) begin
            case ($urandom_range(0, 3))
                0: v = cur_lo;
                1: v = cur_hi;
                2: v = cur_lo - 1;
                default: v = cur_hi + 1;
            endcase
        end
        send_item(mode, v[DATA_W-1:0], idx);
    endtask

    initial begin
        int phase;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_mode = MODE_SAMPLE;
        i_sample = '0;
        i_bucket_index = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_RANGE_MIN;
        i_cfg_data = '0;
        no_idle = 1'b0;
        cur_lo = RANGE_MIN_RST;
        cur_hi = RANGE_MAX_RST;
        cur_n = BUCKET_COUNT_RST;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // -10.0 .. 10.0 over seven buckets
        set_range(-(64'sd10 <<< 16), 64'sd10 <<< 16, 7);
        send_item(MODE_SAMPLE, 32'hFFF6_0000, 8'd0);
        send_item(MODE_SAMPLE, 32'h000A_0000, 8'd0);
        send_item(MODE_SAMPLE, 32'hFFF5_FFFF, 8'd0);
        send_item(MODE_SAMPLE, 32'h000A_0001, 8'd0);
        send_item(MODE_SAMPLE, 32'h8000_0000, 8'hFF);
        send_item(MODE_SAMPLE, 32'h7FFF_FFFF, 8'hFF);
        send_item(MODE_SAMPLE, 32'h0000_0000, 8'd0);
        send_item(MODE_SAMPLE, 32'hFFFF_FFFF, 8'd0);
        send_item(MODE_SAMPLE, 32'hFFF6_0000, 8'd0);
        send_item(MODE_NODATA, 32'h1234_5678, 8'd3);
        send_item(MODE_READ, 32'd0, 8'd0);
        send_item(MODE_READ, 32'd0, 8'd6);
        send_item(MODE_READ, 32'd0, 8'd7);
        send_item(MODE_READ, 32'hFFFF_FFFF, 8'd255);
        send_item(MODE_UNUSED, $urandom(), 8'($urandom()));

        // zero buckets behaves as a single bucket, old counts stay
        set_range(-(64'sd10 <<< 16), 64'sd10 <<< 16, 0);
        send_item(MODE_SAMPLE, 32'h0005_0000, 8'd0);
        send_item(MODE_READ, 32'd0, 8'd0);
        send_item(MODE_READ, 32'd0, 8'd1);

        // full signed range, bucket count above the maximum
        set_range(-(64'sd1 <<< 31), (64'sd1 <<< 31) - 1, 511);
        send_item(MODE_SAMPLE, 32'h8000_0000, 8'd0);
        send_item(MODE_SAMPLE, 32'h7FFF_FFFF, 8'd0);
        send_item(MODE_SAMPLE, 32'h0000_0000, 8'd0);
        send_item(MODE_READ, 32'd0, 8'd255);
        send_item(MODE_READ, 32'd0, 8'd128);

        // empty range: everything is nodata, reads keep counts but lose the border
        set_range(0, 0, 256);
        send_item(MODE_SAMPLE, 32'd0, 8'd0);
        send_item(MODE_READ, 32'd0, 8'd0);
        send_item(MODE_NODATA, 32'd0, 8'd0);

        for (phase = 0; phase < 10; phase++) begin
            random_range();
            no_idle <= (phase % 4 == 1);
            repeat (83) begin
                if ($urandom_range(0, 49) == 0)
                    settle();
                random_item();
            end
        end

        settle();
        repeat (250) @(posedge i_clk);
        if (hist_mismatches == 0 && results_owed == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
